### rtl/acem_pkg.sv
// Shared types and constants for the approximate circuit error metrics block.
`default_nettype none

package acem_pkg;

    localparam int VALUE_W    = 16;
    localparam int FLIPS_W    = 5;
    localparam int NOUT_W     = 5;
    localparam int NV_W       = 21;
    localparam int CNT_W      = 21;
    localparam int SUM_ABS_W  = 37;
    localparam int SUM_SQ_W   = 53;
    localparam int SUM_REL_W  = 53;
    localparam int SQ_W       = 32;
    localparam int REL_W      = 32;
    localparam int ERATE_W    = 17;
    localparam int MSQ_W      = 48;
    localparam int DIV_DW     = 70;
    localparam int DIV_PW     = 6;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 184;

    localparam logic [CFG_ADDR_W-1:0] REG_NUM_VECTORS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_OUTPUTS = 2'd1;

    localparam logic [NOUT_W-1:0]  NOUT_MAX   = 5'd16;
    localparam logic [ERATE_W-1:0] ERATE_MAX  = 17'd65536;
    localparam logic [DIV_PW-1:0]  PAIRS_REL  = 6'd16;
    localparam logic [DIV_PW-1:0]  PAIRS_ERR  = 6'd19;
    localparam logic [DIV_PW-1:0]  PAIRS_ABS  = 6'd27;
    localparam logic [DIV_PW-1:0]  PAIRS_SQ   = 6'd35;
    localparam logic [DIV_PW-1:0]  PAIRS_SREL = 6'd27;

    typedef struct packed {
        logic [FLIPS_W-1:0] flips;
        logic [VALUE_W-1:0] diff;
        logic [VALUE_W-1:0] exact;
        logic               last;
    } item_t;

    typedef struct packed {
        logic              full;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [NV_W-1:0]   divisor;
        logic [DIV_PW-1:0] npairs;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic [REL_W-1:0]   worst_rel_error;
        logic [VALUE_W-1:0] worst_abs_error;
        logic [31:0]        mean_rel_error;
        logic [MSQ_W-1:0]   mean_sq_error;
        logic [31:0]        mean_abs_error;
        logic [ERATE_W-1:0] error_rate;
        logic [FLIPS_W-1:0] worst_bit_flips;
    } res_t;

endpackage

`default_nettype wire

### rtl/acem_front.sv
// Front end: accepts value pairs and derives bit flips and absolute difference.
`default_nettype none

module acem_front (
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [acem_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic                        s_tlast,
    input  wire logic [acem_pkg::NOUT_W-1:0] num_outputs,
    input  wire acem_pkg::q_stat_t           q_stat,
    output logic                             push,
    output acem_pkg::item_t                  push_item
);

    logic [acem_pkg::VALUE_W-1:0] ex;
    logic [acem_pkg::VALUE_W-1:0] ap;
    logic [acem_pkg::NOUT_W-1:0]  nbits;
    logic [acem_pkg::VALUE_W:0]   mask_wide;
    logic [acem_pkg::VALUE_W-1:0] xr;

    assign ex        = s_tdata[15:0];
    assign ap        = s_tdata[31:16];
    assign nbits     = (num_outputs > acem_pkg::NOUT_MAX) ? acem_pkg::NOUT_MAX : num_outputs;
    assign mask_wide = (17'd1 << nbits) - 17'd1;
    assign xr        = (ex ^ ap) & mask_wide[acem_pkg::VALUE_W-1:0];

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        push_item.flips = acem_pkg::FLIPS_W'($countones(xr));
        push_item.diff  = (ap >= ex) ? (ap - ex) : (ex - ap);
        push_item.exact = ex;
        push_item.last  = s_tlast;
    end

endmodule

`default_nettype wire

### rtl/acem_queue.sv
// Two-entry queue between the front end and the back end.
`default_nettype none

module acem_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire acem_pkg::item_t push_item,
    input  wire logic            pop,
    output logic                 pop_valid,
    output acem_pkg::item_t      pop_item,
    output acem_pkg::q_stat_t    q_stat
);

    acem_pkg::item_t                 mem_reg [acem_pkg::QDEPTH];
    logic [acem_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [acem_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [acem_pkg::QCNT_W-1:0]     count_reg;
    logic [acem_pkg::QCNT_W-1:0]     count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_valid    = (count_reg != '0);
    assign pop_item     = mem_reg[rd_ptr_reg];
    assign q_stat.count = count_reg;
    assign q_stat.full  = (count_reg == acem_pkg::QCNT_W'(acem_pkg::QDEPTH));

endmodule

`default_nettype wire

### rtl/acem_divider.sv
// Shared restoring divider producing two quotient bits per cycle.
`default_nettype none

module acem_divider (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire acem_pkg::div_req_t req,
    output acem_pkg::div_rsp_t      rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [acem_pkg::DIV_PW-1:0]   cnt_reg;
    logic [acem_pkg::NV_W-1:0]     rem_reg;
    logic [acem_pkg::NV_W-1:0]     div_reg;
    logic [acem_pkg::DIV_DW-1:0]   dq_reg;

    logic [acem_pkg::NV_W:0]       t1;
    logic [acem_pkg::NV_W:0]       t2;
    logic                          ge1;
    logic                          ge2;
    logic [acem_pkg::NV_W-1:0]     r1;
    logic [acem_pkg::NV_W-1:0]     r2;
    logic [acem_pkg::NV_W:0]       d_ext;

    // The dividend arrives left-aligned, so the quotient ends up in the low bits.
    always_comb begin
        d_ext = {1'b0, div_reg};
        t1    = {rem_reg, dq_reg[acem_pkg::DIV_DW-1]};
        ge1   = (t1 >= d_ext);
        r1    = ge1 ? acem_pkg::NV_W'(t1 - d_ext) : t1[acem_pkg::NV_W-1:0];
        t2    = {r1, dq_reg[acem_pkg::DIV_DW-2]};
        ge2   = (t2 >= d_ext);
        r2    = ge2 ? acem_pkg::NV_W'(t2 - d_ext) : t2[acem_pkg::NV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.npairs;
                rem_reg  <= '0;
                div_reg  <= req.divisor;
                dq_reg   <= req.dividend;
            end else if (busy_reg) begin
                rem_reg <= r2;
                dq_reg  <= {dq_reg[acem_pkg::DIV_DW-3:0], ge1, ge2};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == acem_pkg::DIV_PW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

`default_nettype wire

### rtl/acem_back.sv
// Back end: relative error, saturating accumulators, final means and result register.
`default_nettype none

module acem_back (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      q_valid,
    input  wire acem_pkg::item_t           q_item,
    output logic                           pop,
    input  wire logic [acem_pkg::NV_W-1:0] num_vectors,
    output acem_pkg::div_req_t             div_req,
    input  wire acem_pkg::div_rsp_t        div_rsp,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output acem_pkg::res_t                 res
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_REL, ST_ACC, ST_ERR, ST_ABS, ST_SQ, ST_SREL, ST_EMIT
    } state_t;

    state_t                            state_reg;
    acem_pkg::div_req_t                req_reg;
    logic                              out_valid_reg;
    acem_pkg::res_t                    res_reg;

    logic [acem_pkg::FLIPS_W-1:0]      flips_reg;
    logic [acem_pkg::VALUE_W-1:0]      diff_reg;
    logic                              last_reg;
    logic [acem_pkg::SQ_W-1:0]         sq_reg;
    logic [acem_pkg::REL_W-1:0]        rel_reg;

    logic [acem_pkg::FLIPS_W-1:0]      max_flips_reg;
    logic [acem_pkg::CNT_W-1:0]        err_cnt_reg;
    logic [acem_pkg::SUM_ABS_W-1:0]    sum_abs_reg;
    logic [acem_pkg::SUM_SQ_W-1:0]     sum_sq_reg;
    logic [acem_pkg::SUM_REL_W-1:0]    sum_rel_reg;
    logic [acem_pkg::VALUE_W-1:0]      max_abs_reg;
    logic [acem_pkg::REL_W-1:0]        max_rel_reg;

    logic [acem_pkg::ERATE_W-1:0]      erate_reg;
    logic [31:0]                       mabs_reg;
    logic [acem_pkg::MSQ_W-1:0]        msq_reg;
    logic [31:0]                       mrel_reg;

    logic [acem_pkg::FLIPS_W-1:0]      max_flips_next;
    logic [acem_pkg::CNT_W-1:0]        err_cnt_next;
    logic [acem_pkg::SUM_ABS_W-1:0]    sum_abs_next;
    logic [acem_pkg::SUM_SQ_W-1:0]     sum_sq_next;
    logic [acem_pkg::SUM_REL_W-1:0]    sum_rel_next;
    logic [acem_pkg::VALUE_W-1:0]      max_abs_next;
    logic [acem_pkg::REL_W-1:0]        max_rel_next;
    logic [acem_pkg::SUM_ABS_W:0]      abs_add;
    logic [acem_pkg::SUM_SQ_W:0]       sq_add;
    logic [acem_pkg::SUM_REL_W:0]      rel_add;
    logic [acem_pkg::NV_W-1:0]         nv;
    logic [acem_pkg::DIV_DW-1:0]       quo;

    assign nv  = (num_vectors == '0) ? acem_pkg::NV_W'(1) : num_vectors;
    assign quo = div_rsp.quotient;

    always_comb begin
        abs_add = {1'b0, sum_abs_reg} + (acem_pkg::SUM_ABS_W + 1)'(diff_reg);
        sq_add  = {1'b0, sum_sq_reg} + (acem_pkg::SUM_SQ_W + 1)'(sq_reg);
        rel_add = {1'b0, sum_rel_reg} + (acem_pkg::SUM_REL_W + 1)'(rel_reg);
        sum_abs_next = abs_add[acem_pkg::SUM_ABS_W] ? '1 : abs_add[acem_pkg::SUM_ABS_W-1:0];
        sum_sq_next  = sq_add[acem_pkg::SUM_SQ_W] ? '1 : sq_add[acem_pkg::SUM_SQ_W-1:0];
        sum_rel_next = rel_add[acem_pkg::SUM_REL_W] ? '1 : rel_add[acem_pkg::SUM_REL_W-1:0];
        max_flips_next = (flips_reg > max_flips_reg) ? flips_reg : max_flips_reg;
        max_abs_next   = (diff_reg > max_abs_reg) ? diff_reg : max_abs_reg;
        max_rel_next   = (rel_reg > max_rel_reg) ? rel_reg : max_rel_reg;
        err_cnt_next   = err_cnt_reg;
        if ((flips_reg != '0) && (err_cnt_reg != '1)) begin
            err_cnt_next = err_cnt_reg + 1'b1;
        end
    end

    assign pop = (state_reg == ST_IDLE) && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            req_reg.start <= 1'b0;
            max_flips_reg <= '0;
            err_cnt_reg   <= '0;
            sum_abs_reg   <= '0;
            sum_sq_reg    <= '0;
            sum_rel_reg   <= '0;
            max_abs_reg   <= '0;
            max_rel_reg   <= '0;
        end else begin
            req_reg.start <= 1'b0;
            if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        flips_reg <= q_item.flips;
                        diff_reg  <= q_item.diff;
                        last_reg  <= q_item.last;
                        sq_reg    <= acem_pkg::SQ_W'(q_item.diff) * acem_pkg::SQ_W'(q_item.diff);
                        if (q_item.exact == '0) begin
                            rel_reg   <= {q_item.diff, 16'h0000};
                            state_reg <= ST_ACC;
                        end else begin
                            req_reg.start    <= 1'b1;
                            req_reg.dividend <= {q_item.diff, 16'h0000, 38'h0};
                            req_reg.divisor  <= acem_pkg::NV_W'(q_item.exact);
                            req_reg.npairs   <= acem_pkg::PAIRS_REL;
                            state_reg        <= ST_REL;
                        end
                    end
                end
                ST_REL: begin
                    if (div_rsp.done) begin
                        rel_reg   <= quo[acem_pkg::REL_W-1:0];
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    max_flips_reg <= max_flips_next;
                    err_cnt_reg   <= err_cnt_next;
                    sum_abs_reg   <= sum_abs_next;
                    sum_sq_reg    <= sum_sq_next;
                    sum_rel_reg   <= sum_rel_next;
                    max_abs_reg   <= max_abs_next;
                    max_rel_reg   <= max_rel_next;
                    if (last_reg) begin
                        req_reg.start    <= 1'b1;
                        req_reg.dividend <= {1'b0, err_cnt_next, 16'h0000, 32'h0};
                        req_reg.divisor  <= nv;
                        req_reg.npairs   <= acem_pkg::PAIRS_ERR;
                        state_reg        <= ST_ERR;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_ERR: begin
                    if (div_rsp.done) begin
                        erate_reg <= (quo > acem_pkg::DIV_DW'(acem_pkg::ERATE_MAX)) ?
                                     acem_pkg::ERATE_MAX : quo[acem_pkg::ERATE_W-1:0];
                        req_reg.start    <= 1'b1;
                        req_reg.dividend <= {1'b0, sum_abs_reg, 16'h0000, 16'h0000};
                        req_reg.divisor  <= nv;
                        req_reg.npairs   <= acem_pkg::PAIRS_ABS;
                        state_reg        <= ST_ABS;
                    end
                end
                ST_ABS: begin
                    if (div_rsp.done) begin
                        mabs_reg <= (|quo[acem_pkg::DIV_DW-1:32]) ? '1 : quo[31:0];
                        req_reg.start    <= 1'b1;
                        req_reg.dividend <= {1'b0, sum_sq_reg, 16'h0000};
                        req_reg.divisor  <= nv;
                        req_reg.npairs   <= acem_pkg::PAIRS_SQ;
                        state_reg        <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (div_rsp.done) begin
                        msq_reg <= (|quo[acem_pkg::DIV_DW-1:acem_pkg::MSQ_W]) ?
                                   '1 : quo[acem_pkg::MSQ_W-1:0];
                        req_reg.start    <= 1'b1;
                        req_reg.dividend <= {1'b0, sum_rel_reg, 16'h0000};
                        req_reg.divisor  <= nv;
                        req_reg.npairs   <= acem_pkg::PAIRS_SREL;
                        state_reg        <= ST_SREL;
                    end
                end
                ST_SREL: begin
                    if (div_rsp.done) begin
                        mrel_reg  <= (|quo[acem_pkg::DIV_DW-1:32]) ? '1 : quo[31:0];
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!out_valid_reg || m_tready) begin
                        res_reg.worst_bit_flips <= max_flips_reg;
                        res_reg.error_rate      <= erate_reg;
                        res_reg.mean_abs_error  <= mabs_reg;
                        res_reg.mean_sq_error   <= msq_reg;
                        res_reg.mean_rel_error  <= mrel_reg;
                        res_reg.worst_abs_error <= max_abs_reg;
                        res_reg.worst_rel_error <= max_rel_reg;
                        out_valid_reg <= 1'b1;
                        max_flips_reg <= '0;
                        err_cnt_reg   <= '0;
                        sum_abs_reg   <= '0;
                        sum_sq_reg    <= '0;
                        sum_rel_reg   <= '0;
                        max_abs_reg   <= '0;
                        max_rel_reg   <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign div_req  = req_reg;
    assign m_tvalid = out_valid_reg;
    assign res      = res_reg;

endmodule

`default_nettype wire

### rtl/approx_circuit_error_metrics.sv
// Top level of the approximate circuit error metrics block.
//
//  Channel  Dir  Request fields
//  s_       in   tdata: exact_value, approx_value; tlast: last
//  m_       out  tdata: worst_bit_flips .. worst_rel_error (one request per run)
//  cfg_     in   num_vectors (index 0), num_outputs (index 1)
//
// An ordinary request goes through the shared divider, which forms the relative
// error at two quotient bits per cycle; an exact value of zero skips the division.
// The last request of a run adds four more divisions by num_vectors and a load of
// the result register. Reset is synchronous and active low. A two-entry queue lets
// the input side run ahead while a result waits.
`default_nettype none

module approx_circuit_error_metrics (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // exact_value [15:0], approx_value [31:16]
    input  wire logic [acem_pkg::IN_DATA_W-1:0]   s_tdata,
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // worst_bit_flips [4:0], error_rate [21:5], mean_abs_error [53:22],
    // mean_sq_error [101:54], mean_rel_error [133:102], worst_abs_error [149:134],
    // worst_rel_error [181:150], zero [183:182]
    output logic [acem_pkg::OUT_DATA_W-1:0]       m_tdata,
    input  wire logic                             cfg_wr_en,
    input  wire logic [acem_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [acem_pkg::NV_W-1:0]        cfg_wr_data
);

    logic [acem_pkg::NV_W-1:0]   num_vectors_reg;
    logic [acem_pkg::NOUT_W-1:0] num_outputs_reg;

    logic                        push;
    acem_pkg::item_t             push_item;
    logic                        pop;
    logic                        pop_valid;
    acem_pkg::item_t             pop_item;
    acem_pkg::q_stat_t           q_stat;
    acem_pkg::div_req_t          div_req;
    acem_pkg::div_rsp_t          div_rsp;
    acem_pkg::res_t              res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_vectors_reg <= acem_pkg::NV_W'(1);
            num_outputs_reg <= acem_pkg::NOUT_MAX;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                acem_pkg::REG_NUM_VECTORS: num_vectors_reg <= cfg_wr_data;
                acem_pkg::REG_NUM_OUTPUTS: num_outputs_reg <= cfg_wr_data[acem_pkg::NOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    acem_front u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .num_outputs (num_outputs_reg),
        .q_stat      (q_stat),
        .push        (push),
        .push_item   (push_item)
    );

    acem_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    acem_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    acem_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (pop_valid),
        .q_item      (pop_item),
        .pop         (pop),
        .num_vectors (num_vectors_reg),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .res         (res)
    );

    assign m_tdata = {2'b00, res};

`ifndef ASSERT_OFF
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[21:5] <= acem_pkg::ERATE_MAX))
        else $error("Error rate above one in a result request.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4:0] <= acem_pkg::NOUT_MAX))
        else $error("Worst bit flips exceed the compared width.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_stat.count <= acem_pkg::QCNT_W'(acem_pkg::QDEPTH)))
        else $error("Queue fill count beyond its depth.");
`endif

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the approximate circuit error metrics block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [acem_pkg::CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [acem_pkg::CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;

    localparam int SETTLE_CYCLES = 200;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 1500;
    localparam int RANDOM_ITEMS  = 410;
    localparam int BURST_ITEMS   = 40;

    localparam longint unsigned LIM32   = 64'hFFFF_FFFF;
    localparam longint unsigned LIM48   = (64'd1 << acem_pkg::MSQ_W) - 1;
    localparam longint unsigned CNT_LIM = (64'd1 << acem_pkg::CNT_W) - 1;
    localparam longint unsigned ABS_LIM = (64'd1 << acem_pkg::SUM_ABS_W) - 1;
    localparam longint unsigned SQ_LIM  = (64'd1 << acem_pkg::SUM_SQ_W) - 1;
    localparam longint unsigned REL_LIM = (64'd1 << acem_pkg::SUM_REL_W) - 1;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [acem_pkg::IN_DATA_W-1:0]  s_tdata     = '0;
    logic                            s_tlast     = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [acem_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_wr_en   = 1'b0;
    logic [acem_pkg::CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [acem_pkg::NV_W-1:0]       cfg_wr_data = '0;

    // Shadow registers and accumulators of the metrics predictor.
    logic [acem_pkg::NV_W-1:0]      nv_reg    = 21'd1;
    logic [acem_pkg::NOUT_W-1:0]    nout_reg  = acem_pkg::NOUT_MAX;
    logic [acem_pkg::FLIPS_W-1:0]   flips_top = '0;
    logic [acem_pkg::CNT_W-1:0]     err_cnt   = '0;
    logic [acem_pkg::SUM_ABS_W-1:0] abs_sum   = '0;
    logic [acem_pkg::SUM_SQ_W-1:0]  sq_sum    = '0;
    logic [acem_pkg::SUM_REL_W-1:0] rel_sum   = '0;
    logic [acem_pkg::VALUE_W-1:0]   abs_top   = '0;
    logic [acem_pkg::REL_W-1:0]     rel_top   = '0;

    acem_pkg::res_t expected_metrics[$];

    bit no_gaps   = 1'b0;
    bit hold_kick = 1'b0;
    int hold_left = 0;

    int fail_count  = 0;
    int requests_in = 0;
    int results_out = 0;
    int reg_writes  = 0;

    always #5 aclk = ~aclk;

    approx_circuit_error_metrics uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    function automatic longint unsigned sat_add(longint unsigned acc, longint unsigned x,
                                                longint unsigned lim);
        if (acc > lim) acc = lim;
        if (x > lim - acc) return lim;
        return acc + x;
    endfunction

    function automatic longint unsigned cap(longint unsigned v, longint unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    task automatic clear_metrics();
        flips_top = '0;
        err_cnt   = '0;
        abs_sum   = '0;
        sq_sum    = '0;
        rel_sum   = '0;
        abs_top   = '0;
        rel_top   = '0;
    endtask

    task automatic fold_pair(input logic [acem_pkg::VALUE_W-1:0] ex,
                             input logic [acem_pkg::VALUE_W-1:0] ap, input bit lst);
        int nbits;
        logic [acem_pkg::VALUE_W-1:0] xr;
        longint unsigned flips, diff, sq, rel, nv, q, r;
        acem_pkg::res_t res;
        nbits = (nout_reg > acem_pkg::VALUE_W) ? acem_pkg::VALUE_W : int'(nout_reg);
        xr = (ex ^ ap) & acem_pkg::VALUE_W'((32'd1 << nbits) - 1);
        flips = $countones(xr);
        diff = (ap >= ex) ? longint'(ap - ex) : longint'(ex - ap);
        sq = diff * diff;
        rel = (ex == 0) ? (diff << 16) : ((diff << 16) / ex);
        rel = cap(rel, LIM32);

        if (flips > flips_top) flips_top = acem_pkg::FLIPS_W'(flips);
        if (flips > 0) err_cnt = acem_pkg::CNT_W'(sat_add(err_cnt, 1, CNT_LIM));
        abs_sum = acem_pkg::SUM_ABS_W'(sat_add(abs_sum, diff, ABS_LIM));
        sq_sum  = acem_pkg::SUM_SQ_W'(sat_add(sq_sum, sq, SQ_LIM));
        rel_sum = acem_pkg::SUM_REL_W'(sat_add(rel_sum, rel, REL_LIM));
        if (diff > abs_top) abs_top = acem_pkg::VALUE_W'(diff);
        if (rel > rel_top) rel_top = acem_pkg::REL_W'(rel);
        if (!lst) return;

        nv = (nv_reg == 0) ? 1 : longint'(nv_reg);
        res.worst_bit_flips = acem_pkg::FLIPS_W'(cap(flips_top, 31));
        res.error_rate      = acem_pkg::ERATE_W'(cap((longint'(err_cnt) << 16) / nv, 65536));
        res.mean_abs_error  = 32'(cap((longint'(abs_sum) << 16) / nv, LIM32));
        q = sq_sum / nv;
        r = sq_sum % nv;
        if (q > LIM32) res.mean_sq_error = acem_pkg::MSQ_W'(LIM48);
        else res.mean_sq_error = acem_pkg::MSQ_W'(cap((q << 16) + (r << 16) / nv, LIM48));
        res.mean_rel_error  = 32'(cap(rel_sum / nv, LIM32));
        res.worst_abs_error = abs_top;
        res.worst_rel_error = rel_top;
        expected_metrics.insert(expected_metrics.size(), res);
        clear_metrics();
    endtask

    task automatic send_pair(input logic [acem_pkg::VALUE_W-1:0] ex,
                             input logic [acem_pkg::VALUE_W-1:0] ap, input bit lst);
        while (!no_gaps && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ap, ex};
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        fold_pair(ex, ap, lst);
        requests_in++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_metrics.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [acem_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [acem_pkg::NV_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == acem_pkg::REG_NUM_VECTORS) nv_reg = val;
        else if (idx == acem_pkg::REG_NUM_OUTPUTS) nout_reg = val[acem_pkg::NOUT_W-1:0];
        reg_writes++;
    endtask

    task automatic random_pair(output logic [acem_pkg::VALUE_W-1:0] ex,
                               output logic [acem_pkg::VALUE_W-1:0] ap);
        ex = acem_pkg::VALUE_W'($urandom);
        case ($urandom_range(5))
            0: ap = ex;
            1: ap = ex ^ acem_pkg::VALUE_W'(32'd1 << $urandom_range(acem_pkg::VALUE_W - 1));
            2: ap = ex + acem_pkg::VALUE_W'($urandom_range(1, 15));
            3: ap = acem_pkg::VALUE_W'($urandom);
            4: begin
                ex = '0;
                ap = acem_pkg::VALUE_W'($urandom);
            end
            default: ap = ex - acem_pkg::VALUE_W'($urandom_range(0, 300));
        endcase
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(input logic [acem_pkg::OUT_DATA_W-1:0] word);
        acem_pkg::res_t want, got;
        got = acem_pkg::res_t'(word[$bits(acem_pkg::res_t)-1:0]);
        if (expected_metrics.size() == 0) begin
            $error("metric result arrived with no pending expectation");
            fail_count++;
            return;
        end
        want = expected_metrics.pop_front();
        check_field("worst_bit_flips", want.worst_bit_flips, got.worst_bit_flips);
        check_field("error_rate", want.error_rate, got.error_rate);
        check_field("mean_abs_error", want.mean_abs_error, got.mean_abs_error);
        check_field("mean_sq_error", want.mean_sq_error, got.mean_sq_error);
        check_field("mean_rel_error", want.mean_rel_error, got.mean_rel_error);
        check_field("worst_abs_error", want.worst_abs_error, got.worst_abs_error);
        check_field("worst_rel_error", want.worst_rel_error, got.worst_rel_error);
        check_field("padding", 0, word[acem_pkg::OUT_DATA_W-1:$bits(acem_pkg::res_t)]);
        results_out++;
    endtask

    // Result side: checks each accepted request and decides readiness for the next edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result(m_tdata);
        m_tready <= (hold_left == 0) && !hold_kick && (no_gaps || $urandom_range(99) >= 35);
    end

    always @(posedge aclk) begin
        if (hold_kick) hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    task automatic test_default_registers();
        send_pair(16'h0000, 16'h0000, 1'b1);
        send_pair(16'h0000, 16'hFFFF, 1'b1);
    endtask

    task automatic test_field_extremes();
        send_pair(16'hFFFF, 16'h0000, 1'b0);
        send_pair(16'hFFFF, 16'hFFFF, 1'b0);
        send_pair(16'h0001, 16'hFFFF, 1'b1);
        send_pair(16'h8000, 16'h7FFF, 1'b1);
        send_pair(16'h1234, 16'h1234, 1'b1);
    endtask

    task automatic test_output_width();
        logic [acem_pkg::NV_W-1:0] widths[5];
        widths = '{21'd0, 21'd1, 21'd8, 21'd17, 21'd31};
        foreach (widths[i]) begin
            wait_idle();
            write_reg(acem_pkg::REG_NUM_OUTPUTS, widths[i]);
            send_pair(16'h00F0, 16'hFF0F, 1'b1);
        end
        wait_idle();
        write_reg(acem_pkg::REG_NUM_OUTPUTS, 21'(acem_pkg::NOUT_MAX));
    endtask

    task automatic test_vector_count();
        wait_idle();
        write_reg(acem_pkg::REG_NUM_VECTORS, 21'd0);
        send_pair(16'h0010, 16'h0020, 1'b0);
        send_pair(16'h0005, 16'h0005, 1'b1);
        wait_idle();
        write_reg(acem_pkg::REG_NUM_VECTORS, 21'h100000);
        send_pair(16'hFFFF, 16'h0000, 1'b1);
        wait_idle();
        write_reg(acem_pkg::REG_NUM_VECTORS, 21'h1FFFFF);
        send_pair(16'h0003, 16'h0009, 1'b1);
        wait_idle();
        write_reg(acem_pkg::REG_NUM_VECTORS, 21'd4);
        write_reg(REG_SPARE_A, acem_pkg::NV_W'($urandom));
        write_reg(REG_SPARE_B, acem_pkg::NV_W'($urandom));
        send_pair(16'h0100, 16'h0180, 1'b0);
        send_pair(16'h0000, 16'h0003, 1'b0);
        send_pair(16'h7777, 16'h7777, 1'b0);
        send_pair(16'hAAAA, 16'h5555, 1'b1);
    endtask

    task automatic random_run(input bit allow_config);
        int len;
        logic [acem_pkg::VALUE_W-1:0] ex, ap;
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        if (allow_config && $urandom_range(2) == 0) begin
            wait_idle();
            case ($urandom_range(4))
                0, 1: write_reg(acem_pkg::REG_NUM_VECTORS, acem_pkg::NV_W'(len));
                2: write_reg(acem_pkg::REG_NUM_VECTORS, acem_pkg::NV_W'($urandom_range(1, 64)));
                3: write_reg(acem_pkg::REG_NUM_VECTORS, acem_pkg::NV_W'($urandom));
                default: write_reg(acem_pkg::REG_NUM_VECTORS, 21'd0);
            endcase
            if ($urandom_range(2) == 0)
                write_reg(acem_pkg::REG_NUM_OUTPUTS, acem_pkg::NV_W'($urandom_range(0, 31)));
            else write_reg(acem_pkg::REG_NUM_OUTPUTS, 21'(acem_pkg::NOUT_MAX));
        end
        for (int i = 0; i < len; i++) begin
            random_pair(ex, ap);
            send_pair(ex, ap, i == len - 1);
        end
    endtask

    task automatic test_random_runs();
        int target;
        target = requests_in + RANDOM_ITEMS;
        while (requests_in < target) random_run(1'b1);
    endtask

    task automatic test_back_to_back();
        int target;
        target = requests_in + BURST_ITEMS;
        no_gaps <= 1'b1;
        while (requests_in < target) random_run(1'b0);
        no_gaps <= 1'b0;
    endtask

    task automatic test_backpressure();
        logic [acem_pkg::VALUE_W-1:0] ex, ap;
        wait_idle();
        hold_kick <= 1'b1;
        @(posedge aclk);
        hold_kick <= 1'b0;
        for (int i = 0; i < 10; i++) begin
            random_pair(ex, ap);
            send_pair(ex, ap, 1'b1);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_registers();
        test_field_extremes();
        test_output_width();
        test_vector_count();
        test_random_runs();
        test_back_to_back();
        test_backpressure();

        s_tvalid <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && expected_metrics.size() != 0; w++)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_metrics.size() != 0) begin
            $error("%0d expected metric results never arrived", expected_metrics.size());
            fail_count++;
        end
        $display("Run covered %0d input requests, %0d metric results and %0d register writes,",
                 requests_in, results_out, reg_writes);
        $display("including zero and out-of-range settings, saturation and a long output stall.");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
